// ===== src/ilr_pkg.sv =====
package ilr_pkg;

   localparam int unsigned DataWidthDefault = 64;
   localparam int unsigned ActionWidth = 3;

   typedef enum logic [ActionWidth-1:0] {
      ACT_MOD  = 3'd0,
      ACT_QUO  = 3'd1,
      ACT_REM  = 3'd2,
      ACT_ABS  = 3'd3,
      ACT_GCD  = 3'd4,
      ACT_LCM  = 3'd5,
      ACT_MIN  = 3'd6,
      ACT_MAX  = 3'd7
   } action_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;

endpackage

// ===== src/ilr_divider.sv =====
module ilr_divider import ilr_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output div_ctrl_type          ctrl,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int unsigned CntWidth = $clog2(DATA_WIDTH + 1);

   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvs_ff, dvs_in;
   logic [CntWidth-1:0]   cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DATA_WIDTH-1]};
      trial   = shifted - {1'b0, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CntWidth'(DATA_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DATA_WIDTH]) begin
            rem_in = trial[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_WIDTH-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign done       = done_ff;
   assign quotient   = quo_ff;
   assign remainder  = rem_ff;

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy_ff && $past(busy_ff))
      else $error("done without busy");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("start while busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("busy with zero count");
`endif

endmodule

// ===== src/integer_list_reduce_alu.sv =====
// min/max/abs/first word need no division; mod, quotient, remainder use the serial divider
// gcd: repeated remainder steps on the divider; lcm adds one more division and a
// shift-add multiply that keeps the low DATA_WIDTH bits of the product
// one word at a time; the single serial divider is shared by mod, quo, rem, gcd, lcm
// reset: synchronous active high, clears the list state and the output valid
module integer_list_reduce_alu import ilr_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic signed [63:0] req_operand_value,
   input  logic               req_first_element,
   input  logic               req_last_element,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_result_value,
   output logic               rsp_divide_by_zero
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_GCD, ST_LCM_DIV, ST_LCM_MUL, ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   action_type            act_ff;
   logic [1:0]            seen_ff;
   logic                  err_ff;
   logic                  last_ff;
   logic [DATA_WIDTH-1:0] opv_ff;
   logic [DATA_WIDTH-1:0] gx_ff, gy_ff;
   logic                  rsp_valid_ff;
   logic [63:0]           rsp_value_ff;
   logic                  rsp_dbz_ff;

   logic                  div_start_ff;
   logic [DATA_WIDTH-1:0] div_a_ff, div_b_ff, div_q, div_r;
   logic                  div_done;
   div_ctrl_type          div_ctrl;

   logic [DATA_WIDTH-1:0] in_v, mag_acc, mag_v, mag_a_res, lcm_res, div_res;
   logic                  accept, neg_acc, neg_v;

   function automatic logic [DATA_WIDTH-1:0] magf(input logic [DATA_WIDTH-1:0] x);
      return x[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - x) : x;
   endfunction

   assign in_v    = req_operand_value[DATA_WIDTH-1:0];
   assign accept  = req_valid && req_ready;
   assign neg_acc = acc_ff[DATA_WIDTH-1];
   assign neg_v   = opv_ff[DATA_WIDTH-1];
   assign mag_acc = magf(acc_ff);
   assign mag_v   = magf(opv_ff);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      unique case (act_ff)
         ACT_QUO: div_res = (neg_acc != neg_v) ? DATA_WIDTH'(0) - div_q : div_q;
         ACT_REM: div_res = neg_acc ? DATA_WIDTH'(0) - div_r : div_r;
         default: div_res = (neg_acc && div_r != '0) ? mag_v - div_r : div_r;
      endcase
      mag_a_res = magf(acc_ff);
      lcm_res   = neg_acc ? DATA_WIDTH'(0) - acc_ff : acc_ff;
   end

   ilr_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start_ff),
      .dividend  (div_a_ff),
      .divisor   (div_b_ff),
      .ctrl      (div_ctrl),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         act_ff       <= ACT_MOD;
         seen_ff      <= 2'd0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         if (div_start_ff) begin
            div_start_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_ff <= req_last_element;
                  opv_ff  <= in_v;
                  if (req_first_element) begin
                     act_ff  <= action_type'(req_action);
                     acc_ff  <= in_v;
                     seen_ff <= 2'd1;
                     err_ff  <= 1'b0;
                     if (req_last_element) state_ff <= ST_EMIT;
                  end else if (seen_ff != 2'd0) begin
                     seen_ff <= 2'd2;
                     unique case (act_ff)
                        ACT_MOD, ACT_QUO, ACT_REM: begin
                           if (seen_ff == 2'd1) begin
                              if (magf(in_v) == '0) begin
                                 err_ff <= 1'b1;
                                 acc_ff <= '0;
                                 if (req_last_element) state_ff <= ST_EMIT;
                              end else begin
                                 div_a_ff     <= mag_acc;
                                 div_b_ff     <= magf(in_v);
                                 div_start_ff <= 1'b1;
                                 state_ff     <= ST_DIV;
                              end
                           end else if (req_last_element) begin
                              state_ff <= ST_EMIT;
                           end
                        end
                        ACT_ABS: begin
                           if (req_last_element) state_ff <= ST_EMIT;
                        end
                        ACT_GCD: begin
                           gx_ff    <= mag_acc;
                           gy_ff    <= magf(in_v);
                           state_ff <= ST_GCD;
                        end
                        ACT_LCM: begin
                           if (mag_acc == '0 || magf(in_v) == '0) begin
                              acc_ff <= '0;
                              if (req_last_element) state_ff <= ST_EMIT;
                           end else begin
                              gx_ff    <= mag_acc;
                              gy_ff    <= magf(in_v);
                              state_ff <= ST_GCD;
                           end
                        end
                        ACT_MIN: begin
                           if ($signed(in_v) < $signed(acc_ff)) acc_ff <= in_v;
                           if (req_last_element) state_ff <= ST_EMIT;
                        end
                        default: begin
                           if ($signed(acc_ff) < $signed(in_v)) acc_ff <= in_v;
                           if (req_last_element) state_ff <= ST_EMIT;
                        end
                     endcase
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  acc_ff   <= div_res;
                  state_ff <= last_ff ? ST_EMIT : ST_IDLE;
               end
            end
            ST_GCD: begin
               if (!div_ctrl.busy && !div_start_ff) begin
                  if (div_done) begin
                     gx_ff <= gy_ff;
                     gy_ff <= div_r;
                  end else if (gy_ff == '0) begin
                     if (act_ff == ACT_GCD) begin
                        acc_ff   <= gx_ff;
                        state_ff <= last_ff ? ST_EMIT : ST_IDLE;
                     end else begin
                        div_a_ff     <= mag_acc;
                        div_b_ff     <= gx_ff;
                        div_start_ff <= 1'b1;
                        state_ff     <= ST_LCM_DIV;
                     end
                  end else begin
                     div_a_ff     <= gx_ff;
                     div_b_ff     <= gy_ff;
                     div_start_ff <= 1'b1;
                  end
               end
            end
            ST_LCM_DIV: begin
               if (div_done) begin
                  gx_ff    <= neg_acc ? DATA_WIDTH'(0) - div_q : div_q;
                  gy_ff    <= opv_ff;
                  acc_ff   <= '0;
                  state_ff <= ST_LCM_MUL;
               end
            end
            ST_LCM_MUL: begin
               // shift-add multiply, low DATA_WIDTH bits of the product
               if (gy_ff == '0) begin
                  state_ff <= last_ff ? ST_EMIT : ST_IDLE;
               end else begin
                  if (gy_ff[0]) acc_ff <= acc_ff + gx_ff;
                  gx_ff <= {gx_ff[DATA_WIDTH-2:0], 1'b0};
                  gy_ff <= {1'b0, gy_ff[DATA_WIDTH-1:1]};
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_dbz_ff   <= err_ff;
                  if (err_ff || (act_ff <= ACT_REM && seen_ff == 2'd1)) begin
                     rsp_value_ff <= '0;
                  end else if (act_ff == ACT_ABS) begin
                     rsp_value_ff <= 64'(signed'(mag_a_res));
                  end else if (act_ff == ACT_LCM) begin
                     rsp_value_ff <= 64'(signed'(lcm_res));
                  end else begin
                     rsp_value_ff <= 64'(signed'(acc_ff));
                  end
                  seen_ff  <= 2'd0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = rsp_value_ff;
   assign rsp_divide_by_zero = rsp_dbz_ff;

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> rsp_result_value == '0)
      else $error("error result not zero");
   a_emit_rsp: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_EMIT && state_ff == ST_IDLE) |-> rsp_valid)
      else $error("emit without response");
`endif

endmodule

// ===== test/integer_list_reduce_alu_test.sv =====
module integer_list_reduce_alu_test import ilr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  action;
      logic [63:0] operand;
      logic        first;
      logic        last;
   } word_type;

   typedef struct {
      logic [63:0] value;
      logic        dbz;
   } result_type;

   localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
   localparam longint unsigned CYCLE_LIMIT = 64'd10_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic signed [63:0] req_operand_value = '0;
   logic        req_first_element = 1'b0;
   logic        req_last_element = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [63:0] rsp_result_value;
   logic        rsp_divide_by_zero;

   word_type   pending_words[$];
   result_type expected_results[$];
   logic    took_word = 1'b0;
   logic    calm = 1'b0;
   int      errors = 0;
   int      words_sent = 0;
   int      results_seen = 0;
   longint unsigned cycles = 0;

   logic [63:0] acc;
   logic [2:0]  cur_action;
   logic [1:0]  seen;
   logic        err_flag;

   integer_list_reduce_alu u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .req_operand_value(req_operand_value),
      .req_first_element(req_first_element), .req_last_element(req_last_element),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_value(rsp_result_value), .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] magnitude(logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = y;
         y = x % y;
         x = t;
      end
      return x;
   endfunction

   function automatic void divide_into(logic [63:0] b);
      logic [63:0] ma, mb, q, r;
      ma = magnitude(acc);
      mb = magnitude(b);
      if (mb == 0) begin
         err_flag = 1'b1;
         acc = '0;
         return;
      end
      q = ma / mb;
      r = ma % mb;
      case (action_type'(cur_action))
         ACT_QUO: acc = (acc[63] != b[63]) ? -q : q;
         ACT_REM: acc = acc[63] ? -r : r;
         default: acc = (acc[63] && r != 0) ? mb - r : r;
      endcase
   endfunction

   function automatic void fold_word(logic [63:0] v);
      logic [63:0] mr, mv, q;
      case (action_type'(cur_action))
         ACT_MOD, ACT_QUO, ACT_REM: if (seen == 2'd1) divide_into(v);
         ACT_ABS: ;
         ACT_GCD: acc = gcd_of(magnitude(acc), magnitude(v));
         ACT_LCM: begin
            mr = magnitude(acc);
            mv = magnitude(v);
            if (mr == 0 || mv == 0) begin
               acc = '0;
            end else begin
               q = mr / gcd_of(mr, mv);
               if (acc[63]) q = -q;
               acc = q * v;
            end
         end
         ACT_MIN: if ($signed(v) < $signed(acc)) acc = v;
         default: if ($signed(acc) < $signed(v)) acc = v;
      endcase
      seen = 2'd2;
   endfunction

   function automatic void predict_list_result(word_type w);
      result_type r;
      if (w.first) begin
         cur_action = w.action;
         acc = w.operand;
         seen = 2'd1;
         err_flag = 1'b0;
      end else if (seen == 2'd0) begin
         return;
      end else begin
         fold_word(w.operand);
      end
      if (!w.last) return;
      if (err_flag) r.value = '0;
      else if (cur_action <= ACT_REM && seen == 2'd1) r.value = '0;
      else if (cur_action == ACT_ABS) r.value = magnitude(acc);
      else if (cur_action == ACT_LCM) r.value = acc[63] ? -acc : acc;
      else r.value = acc;
      r.dbz = err_flag;
      expected_results = {expected_results, r};
      seen = 2'd0;
   endfunction

   function automatic logic [63:0] rand_operand();
      logic [63:0] v;
      case ($urandom_range(0, 7))
         0: v = {$urandom, $urandom};
         1: v = 64'($urandom_range(0, 40)) - 64'd20;
         2: v = MOST_NEG;
         3: v = MOST_POS;
         4: v = 64'd0;
         5: v = 64'($urandom_range(1, 5000)) * 64'($urandom_range(1, 5000));
         6: v = -(64'($urandom_range(1, 5000)) * 64'($urandom_range(1, 5000)));
         default: v = 64'($urandom_range(0, 1000000)) - 64'd500000;
      endcase
      return v;
   endfunction

   function automatic void add_word(logic [2:0] a, logic [63:0] v, logic f, logic l);
      word_type w;
      w.action = a;
      w.operand = v;
      w.first = f;
      w.last = l;
      pending_words = {pending_words, w};
   endfunction

   function automatic void add_list(action_type a, int n);
      for (int i = 0; i < n; i++)
         add_word(i == 0 ? a : 3'($urandom), rand_operand(), i == 0, i == n - 1);
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || took_word) begin
            if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
               req_action <= pending_words[0].action;
               req_operand_value <= pending_words[0].operand;
               req_first_element <= pending_words[0].first;
               req_last_element <= pending_words[0].last;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm || $urandom_range(0, 99) >= 26;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      took_word <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         predict_list_result(pending_words.pop_front());
         words_sent <= words_sent + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $error("result with no word pending: value %0d", rsp_result_value);
            errors = errors + 1;
         end else begin
            if (rsp_result_value !== $signed(expected_results[0].value)) begin
               $error("result_value expected %0d actual %0d",
                      $signed(expected_results[0].value), rsp_result_value);
               errors = errors + 1;
            end
            if (rsp_divide_by_zero !== expected_results[0].dbz) begin
               $error("divide_by_zero expected %0b actual %0b",
                      expected_results[0].dbz, rsp_divide_by_zero);
               errors = errors + 1;
            end
            void'(expected_results.pop_front());
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int n;
      acc = '0;
      cur_action = '0;
      seen = '0;
      err_flag = 1'b0;
      add_word(ACT_MAX, 64'd5, 1'b0, 1'b1);
      add_word(ACT_MOD, -64'd7, 1'b1, 1'b0);
      add_word(ACT_MOD, 64'd3, 1'b0, 1'b1);
      add_word(ACT_QUO, MOST_NEG, 1'b1, 1'b0);
      add_word(ACT_QUO, -64'd1, 1'b0, 1'b1);
      add_word(ACT_REM, -64'd7, 1'b1, 1'b0);
      add_word(ACT_REM, 64'd0, 1'b0, 1'b1);
      add_word(ACT_REM, 64'd9, 1'b1, 1'b1);
      add_word(ACT_QUO, 64'd100, 1'b1, 1'b0);
      add_word(ACT_QUO, -64'd7, 1'b0, 1'b0);
      add_word(ACT_QUO, 64'd0, 1'b0, 1'b1);
      add_word(ACT_ABS, MOST_NEG, 1'b1, 1'b0);
      add_word(ACT_ABS, 64'd3, 1'b0, 1'b1);
      add_word(ACT_GCD, -64'd42, 1'b1, 1'b1);
      add_word(ACT_GCD, MOST_NEG, 1'b1, 1'b0);
      add_word(ACT_GCD, 64'd0, 1'b0, 1'b1);
      add_word(ACT_LCM, -64'd4, 1'b1, 1'b0);
      add_word(ACT_LCM, 64'd6, 1'b0, 1'b0);
      add_word(ACT_LCM, 64'd0, 1'b0, 1'b1);
      add_word(ACT_MIN, MOST_POS, 1'b1, 1'b0);
      add_word(ACT_MIN, MOST_NEG, 1'b0, 1'b1);
      add_word(ACT_MAX, MOST_NEG, 1'b1, 1'b0);
      add_word(ACT_MAX, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);
      add_word(ACT_MAX, MOST_POS, 1'b0, 1'b1);
      while (pending_words.size() < 100) begin
         n = $urandom_range(0, 9);
         if (n == 0) add_word(3'($urandom), rand_operand(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
         else add_list(action_type'($urandom_range(0, 7)), $urandom_range(1, 5));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait (words_sent >= 40);
      calm <= 1'b1;
      wait (words_sent >= 70);
      calm <= 1'b0;
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (200) @(posedge clock);
      $display("sent %0d words covering all eight operations, checked %0d results",
               words_sent, results_seen);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
